// ----- design/tdc_pkg.sv -----
// Shared widths, constants and stage payload types of the timer deadline coalescer.
`timescale 1ns / 1ps
`default_nettype none

package tdc_pkg;

  // Field widths
  localparam int SEC_W  = 32;  // current time, whole seconds
  localparam int USEC_W = 20;  // microsecond fraction
  localparam int IVL_W  = 31;  // interval in milliseconds
  localparam int KIND_W = 2;   // timer kind
  localparam int WSEC_W = 33;  // wake-up time, whole seconds
  localparam int ISEC_W = 22;  // whole seconds of the interval
  localparam int MS_W   = 10;  // millisecond fraction

  // Pipeline split: reciprocal division, coarse rounding, deadline settling
  localparam int DIV_STAGES = 2;
  localparam int RND_STAGES = 3;
  localparam int SET_STAGES = 3;
  localparam int NUM_STAGES = DIV_STAGES + RND_STAGES + SET_STAGES;

  // Time constants
  localparam int MS_PER_SEC   = 1000;
  localparam int USEC_PER_SEC = 1000000;
  localparam logic [USEC_W-1:0] MAX_USEC  = 20'd999999;
  localparam logic [USEC_W-1:0] HALF_USEC = 20'd500000;

  // Interval / 1000: floor(2^41 / 1000), one correction step afterwards
  localparam int IVL_SHIFT  = 41;
  localparam int IVL_PROD_W = IVL_W + 32;
  localparam logic [31:0] IVL_RECIP = 32'd2199023255;

  // Microseconds / 1000: floor(2^30 / 1000), one correction step afterwards
  localparam int USEC_SHIFT  = 30;
  localparam int USEC_PROD_W = USEC_W + 21;
  localparam logic [20:0] USEC_RECIP = 21'd1073741;

  // Exact division of values below 1000 by 25 and of values below 250 by 5
  localparam int SHIFT25  = 15;
  localparam int RECIP25  = 1311;
  localparam int SHIFT5   = 10;
  localparam int RECIP5   = 205;

  // Timer kinds; the reserved code behaves as a coarse timer
  localparam logic [KIND_W-1:0] KIND_PRECISE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VERY_COARSE = 2'd2;

  // Division stage output
  typedef struct packed {
    logic [SEC_W-1:0]  nsec;
    logic [USEC_W-1:0] usec;
    logic [KIND_W-1:0] kind;
    logic [ISEC_W-1:0] isec;
    logic [MS_W-1:0]   ims;
    logic [MS_W-1:0]   cm;
  } split_t;

  // Context that travels with an item through rounding and settling
  typedef struct packed {
    logic [SEC_W-1:0]  nsec;
    logic [USEC_W-1:0] usec;
    logic [KIND_W-1:0] kind;
    logic [ISEC_W-1:0] isec;
    logic [USEC_W-1:0] ims_us;
  } ctx_t;

  // Rounding stage output
  typedef struct packed {
    ctx_t              ctx;
    logic [WSEC_W-1:0] bsec;
    logic [MS_W-1:0]   msec;
  } round_t;

  // Result beat
  typedef struct packed {
    logic [WSEC_W-1:0] when_sec;
    logic [USEC_W-1:0] when_usec;
    logic [SEC_W-1:0]  delta_sec;
    logic [USEC_W-1:0] delta_usec;
  } result_t;

endpackage

`default_nettype wire

// ----- design/tdc_if.sv -----
// Valid/ready channel interfaces for timer items and wake-up results.
`timescale 1ns / 1ps
`default_nettype none

interface tdc_in_if import tdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SEC_W-1:0]  now_sec;
  logic [USEC_W-1:0] now_usec;
  logic [IVL_W-1:0]  interval_ms;
  logic [KIND_W-1:0] kind;

  modport source (output valid, now_sec, now_usec, interval_ms, kind, input ready);
  modport sink   (input valid, now_sec, now_usec, interval_ms, kind, output ready);
endinterface

interface tdc_out_if import tdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WSEC_W-1:0] when_sec;
  logic [USEC_W-1:0] when_usec;
  logic [SEC_W-1:0]  delta_sec;
  logic [USEC_W-1:0] delta_usec;

  modport source (output valid, when_sec, when_usec, delta_sec, delta_usec, input ready);
  modport sink   (input valid, when_sec, when_usec, delta_sec, delta_usec, output ready);
endinterface

`default_nettype wire

// ----- design/timer_deadline_coalescer.sv -----
// Top level of the timer deadline coalescer: stage valid bits, stall chain and channels.
`timescale 1ns / 1ps
`default_nettype none

// Takes one timer item per beat (current time, interval in ms, kind) and returns one
// result beat with the wake-up time and the delay until it. The block is an eight-stage
// pipeline: two stages divide the interval and the microseconds by 1000 with a
// reciprocal multiply and a correction, three form the millisecond fraction and round
// coarse timers toward preferred boundaries, and three assemble the deadline, add the
// interval again for a coarse deadline in the past, and subtract now. One item is accepted
// every cycle while ready is high; a stalled result holds its own stage
// only, so bubbles further up keep filling and ready drops only when all eight stages
// are occupied. Microseconds above 999999 are taken as 999999, and kind 3 is coarse.
module timer_deadline_coalescer import tdc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  tdc_in_if.sink   item,
  tdc_out_if.source result
);

  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] en;
  split_t                split;
  round_t                rnd;
  result_t               res;

  // A stage advances when it is empty or the stage after it advances
  always_comb begin
    en[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || result.ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !stage_valid[i] || en[i+1];
    end
  end

  // Move valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (en[0]) begin
        stage_valid[0] <= item.valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  assign item.ready = en[0];

  tdc_divide u_divide (
    .clk         (clk),
    .en          (en[DIV_STAGES-1:0]),
    .now_sec     (item.now_sec),
    .now_usec    (item.now_usec),
    .interval_ms (item.interval_ms),
    .kind        (item.kind),
    .split       (split)
  );

  tdc_round u_round (
    .clk   (clk),
    .en    (en[DIV_STAGES +: RND_STAGES]),
    .split (split),
    .rnd   (rnd)
  );

  tdc_settle u_settle (
    .clk (clk),
    .en  (en[DIV_STAGES + RND_STAGES +: SET_STAGES]),
    .rnd (rnd),
    .res (res)
  );

  // Drive the result beat from the last stage
  assign result.valid      = stage_valid[NUM_STAGES-1];
  assign result.when_sec   = res.when_sec;
  assign result.when_usec  = res.when_usec;
  assign result.delta_sec  = res.delta_sec;
  assign result.delta_usec = res.delta_usec;

`ifndef SYNTH
  // Input back-pressure only when every stage holds an item
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (&stage_valid))
    else $error("input stalled while a pipeline stage was empty");

  // Microsecond fields of a delivered result stay inside one second
  a_usec_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.when_usec <= MAX_USEC) && (result.delta_usec <= MAX_USEC)))
    else $error("result microseconds out of range");
`endif

endmodule

`default_nettype wire

// ----- design/tdc_divide.sv -----
// Two-stage reciprocal division of the interval and of the microseconds by 1000.
`timescale 1ns / 1ps
`default_nettype none

module tdc_divide import tdc_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [SEC_W-1:0]      now_sec,
  input  logic [USEC_W-1:0]     now_usec,
  input  logic [IVL_W-1:0]      interval_ms,
  input  logic [KIND_W-1:0]     kind,
  output split_t                split
);

  localparam int REM_W = 11;

  logic [USEC_W-1:0]      usec_clamp;
  logic [IVL_PROD_W-1:0]  ivl_prod;
  logic [USEC_PROD_W-1:0] usec_prod;

  logic [SEC_W-1:0]  s1_nsec;
  logic [USEC_W-1:0] s1_usec;
  logic [IVL_W-1:0]  s1_ivl;
  logic [KIND_W-1:0] s1_kind;
  logic [ISEC_W-1:0] s1_iq;
  logic [MS_W-1:0]   s1_uq;

  logic [31:0]       ivl_back;
  logic [31:0]       ivl_rem;
  logic [REM_W-1:0]  irem;
  logic [USEC_W-1:0] usec_back;
  logic [USEC_W-1:0] usec_rem;
  logic [REM_W-1:0]  urem;
  split_t            split_next;

  // Clamp the microseconds and estimate both quotients, at most one low
  assign usec_clamp = (now_usec > MAX_USEC) ? MAX_USEC : now_usec;
  assign ivl_prod   = IVL_PROD_W'(interval_ms) * IVL_PROD_W'(IVL_RECIP);
  assign usec_prod  = USEC_PROD_W'(usec_clamp) * USEC_PROD_W'(USEC_RECIP);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_nsec <= now_sec;
      s1_usec <= usec_clamp;
      s1_ivl  <= interval_ms;
      s1_kind <= kind;
      s1_iq   <= ivl_prod[IVL_SHIFT +: ISEC_W];
      s1_uq   <= usec_prod[USEC_SHIFT +: MS_W];
    end
  end

  // Correct the estimates: a remainder of 1000 or more bumps the quotient
  assign ivl_back  = 32'(s1_iq) * 32'(MS_PER_SEC);
  assign ivl_rem   = 32'(s1_ivl) - ivl_back;
  assign irem      = ivl_rem[REM_W-1:0];
  assign usec_back = USEC_W'(s1_uq) * USEC_W'(MS_PER_SEC);
  assign usec_rem  = s1_usec - usec_back;
  assign urem      = usec_rem[REM_W-1:0];

  always_comb begin
    split_next.nsec = s1_nsec;
    split_next.usec = s1_usec;
    split_next.kind = s1_kind;
    if (irem >= REM_W'(MS_PER_SEC)) begin
      split_next.isec = s1_iq + ISEC_W'(1);
      split_next.ims  = MS_W'(irem - REM_W'(MS_PER_SEC));
    end else begin
      split_next.isec = s1_iq;
      split_next.ims  = irem[MS_W-1:0];
    end
    if (urem >= REM_W'(MS_PER_SEC)) begin
      split_next.cm = s1_uq + MS_W'(1);
    end else begin
      split_next.cm = s1_uq;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      split <= split_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/tdc_round.sv -----
// Three-stage millisecond sum and coarse rounding toward preferred boundaries.
`timescale 1ns / 1ps
`default_nettype none

module tdc_round import tdc_pkg::*; (
  input  logic                  clk,
  input  logic [RND_STAGES-1:0] en,
  input  split_t                split,
  output round_t                rnd
);

  localparam int Q_W = 6;  // quotient of a millisecond value by 25 or 20

  typedef enum logic [2:0] {
    BND_25  = 3'd0,
    BND_50  = 3'd1,
    BND_100 = 3'd2,
    BND_200 = 3'd3,
    BND_250 = 3'd4,
    BND_500 = 3'd5
  } bnd_t;

  // Stage 3 logic
  logic [MS_W:0]     msum;
  logic              ms_carry;
  logic [20:0]       ims_prod;
  logic [Q_W-1:0]    ims_d25;
  logic              ims_mult25;
  logic [4:0]        ims_d50;
  logic [15:0]       d20_prod;
  logic [MS_W:0]     isec_x50;
  logic [MS_W-1:0]   maxr_next;
  bnd_t              bnd_next;
  ctx_t              ctx_next;

  // Stage 3 registers
  ctx_t              s3_ctx;
  logic [WSEC_W-1:0] s3_bsec;
  logic [MS_W-1:0]   s3_msec;
  logic [MS_W-1:0]   s3_maxr;
  logic              s3_small;
  logic              s3_narrow;
  logic              s3_on_half;
  logic              s3_long;
  bnd_t              s3_bnd;

  // Stage 4 logic
  logic [20:0]       m_prod;
  logic [MS_W:0]     hsum;

  // Stage 4 registers
  ctx_t              s4_ctx;
  logic [WSEC_W-1:0] s4_bsec;
  logic [MS_W-1:0]   s4_msec;
  logic [Q_W-1:0]    s4_m25;
  logic [MS_W-1:0]   s4_lo;
  logic [MS_W-1:0]   s4_hi;
  logic              s4_lo_zero;
  logic              s4_hi_full;
  logic              s4_small;
  logic              s4_narrow;
  logic              s4_on_half;
  logic              s4_long;
  bnd_t              s4_bnd;

  // Stage 5 logic
  logic              up;
  logic [MS_W-1:0]   small_ms;
  logic [MS_W-1:0]   base;
  logic [MS_W-1:0]   step;
  logic [MS_W:0]     mid;
  logic [MS_W:0]     upper;
  logic [MS_W-1:0]   snap_ms;
  logic [MS_W-1:0]   msec_next;

  // Millisecond fraction of now plus interval, carry into the seconds
  assign msum     = (MS_W + 1)'(split.cm) + (MS_W + 1)'(split.ims);
  assign ms_carry = msum >= (MS_W + 1)'(MS_PER_SEC);

  // Interval classes; the fraction bits of the /25 product are below RECIP25
  // exactly for multiples of 25
  assign ims_prod   = 21'(split.ims) * 21'(RECIP25);
  assign ims_d25    = ims_prod[SHIFT25 +: Q_W];
  assign ims_mult25 = ims_prod[SHIFT25-1:0] < SHIFT25'(RECIP25);
  assign ims_d50    = ims_d25[Q_W-1:1];

  // Largest shift allowed, interval/20, clamped at one second
  assign d20_prod  = 16'(split.ims[MS_W-1:2]) * 16'(RECIP5);
  assign isec_x50  = (MS_W + 1)'(split.isec[4:0]) * (MS_W + 1)'(50);
  assign maxr_next = (split.isec >= ISEC_W'(20)) ? MS_W'(MS_PER_SEC)
                   : MS_W'(isec_x50) + MS_W'(d20_prod[SHIFT5 +: Q_W]);

  // Pick the preferred boundary
  always_comb begin
    if (split.ims == MS_W'(0) || split.ims == MS_W'(500)) begin
      bnd_next = BND_500;
    end else if (ims_mult25 && !ims_d25[0]) begin
      if (ims_d50[1:0] == 2'd0) begin
        bnd_next = BND_200;
      end else if (!ims_d50[0]) begin
        bnd_next = BND_100;
      end else if (ims_d50 inside {5'd5, 5'd15}) begin
        bnd_next = BND_250;
      end else begin
        bnd_next = BND_50;
      end
    end else begin
      bnd_next = BND_25;
    end
  end

  always_comb begin
    ctx_next.nsec   = split.nsec;
    ctx_next.usec   = split.usec;
    ctx_next.kind   = split.kind;
    ctx_next.isec   = split.isec;
    ctx_next.ims_us = USEC_W'(split.ims) * USEC_W'(MS_PER_SEC);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s3_ctx     <= ctx_next;
      s3_bsec    <= WSEC_W'(split.nsec) + WSEC_W'(split.isec) + WSEC_W'(ms_carry);
      s3_msec    <= ms_carry ? MS_W'(msum - (MS_W + 1)'(MS_PER_SEC)) : msum[MS_W-1:0];
      s3_maxr    <= maxr_next;
      s3_small   <= (split.isec == '0) && (split.ims < MS_W'(100)) && !ims_mult25;
      s3_narrow  <= split.ims < MS_W'(50);
      s3_on_half <= (split.ims == MS_W'(0)) || (split.ims == MS_W'(500));
      s3_long    <= split.isec >= ISEC_W'(5);
      s3_bnd     <= bnd_next;
    end
  end

  // Window around the fraction, and the fraction divided by 25
  assign m_prod = 21'(s3_msec) * 21'(RECIP25);
  assign hsum   = (MS_W + 1)'(s3_msec) + (MS_W + 1)'(s3_maxr);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s4_ctx     <= s3_ctx;
      s4_bsec    <= s3_bsec;
      s4_msec    <= s3_msec;
      s4_m25     <= m_prod[SHIFT25 +: Q_W];
      s4_lo_zero <= s3_msec <= s3_maxr;
      s4_lo      <= (s3_msec > s3_maxr) ? s3_msec - s3_maxr : '0;
      s4_hi_full <= hsum >= (MS_W + 1)'(MS_PER_SEC);
      s4_hi      <= (hsum >= (MS_W + 1)'(MS_PER_SEC)) ? MS_W'(MS_PER_SEC) : hsum[MS_W-1:0];
      s4_small   <= s3_small;
      s4_narrow  <= s3_narrow;
      s4_on_half <= s3_on_half;
      s4_long    <= s3_long;
      s4_bnd     <= s3_bnd;
    end
  end

  // Short odd intervals: round to even or to a multiple of 4
  assign up       = s4_narrow ? s4_m25[0] : s4_m25[1];
  assign small_ms = s4_narrow ? {s4_msec[MS_W-1:2], s4_msec[1] | up, 1'b0}
                              : {s4_msec[MS_W-1:3], s4_msec[2] | up, 2'b00};

  // Boundary below the fraction
  always_comb begin
    base = '0;
    step = MS_W'(25);
    case (s4_bnd)
      BND_25: begin
        base = MS_W'(s4_m25) * MS_W'(25);
        step = MS_W'(25);
      end
      BND_50: begin
        base = MS_W'(s4_m25[Q_W-1:1]) * MS_W'(50);
        step = MS_W'(50);
      end
      BND_100: begin
        base = MS_W'(s4_m25[Q_W-1:2]) * MS_W'(100);
        step = MS_W'(100);
      end
      BND_200: begin
        base = MS_W'(s4_m25[Q_W-1:3]) * MS_W'(200);
        step = MS_W'(200);
      end
      BND_250: begin
        if (s4_msec >= MS_W'(750)) begin
          base = MS_W'(750);
        end else if (s4_msec >= MS_W'(500)) begin
          base = MS_W'(500);
        end else if (s4_msec >= MS_W'(250)) begin
          base = MS_W'(250);
        end else begin
          base = '0;
        end
        step = MS_W'(250);
      end
      BND_500: begin
        base = (s4_msec >= MS_W'(500)) ? MS_W'(500) : '0;
        step = MS_W'(500);
      end
      default: begin
        base = '0;
        step = MS_W'(25);
      end
    endcase
  end

  // Snap down or up to the nearer boundary, kept inside the window
  assign mid   = (MS_W + 1)'(base) + (MS_W + 1)'(step >> 1);
  assign upper = (MS_W + 1)'(base) + (MS_W + 1)'(step);

  always_comb begin
    if ((MS_W + 1)'(s4_msec) < mid) begin
      snap_ms = (base > s4_lo) ? base : s4_lo;
    end else begin
      snap_ms = (upper < (MS_W + 1)'(s4_hi)) ? MS_W'(upper) : s4_hi;
    end
  end

  always_comb begin
    if (s4_small) begin
      msec_next = small_ms;
    end else if (s4_lo_zero) begin
      msec_next = '0;
    end else if (s4_hi_full) begin
      msec_next = MS_W'(MS_PER_SEC);
    end else if (s4_on_half && s4_long) begin
      msec_next = (s4_msec >= MS_W'(500)) ? s4_hi : s4_lo;
    end else begin
      msec_next = snap_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rnd.ctx  <= s4_ctx;
      rnd.bsec <= s4_bsec;
      rnd.msec <= msec_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/tdc_settle.sv -----
// Three-stage deadline assembly per timer kind, past-deadline fix and delay subtraction.
`timescale 1ns / 1ps
`default_nettype none

module tdc_settle import tdc_pkg::*; (
  input  logic                  clk,
  input  logic [SET_STAGES-1:0] en,
  input  round_t                rnd,
  output result_t               res
);

  // Stage 6 logic
  logic              up_sec;
  logic [WSEC_W-1:0] w1_sec;
  logic [USEC_W-1:0] w1_usec;
  logic              w1_past;
  logic [WSEC_W-1:0] vc_sec;
  logic [WSEC_W-1:0] x_sec;
  logic [USEC_W-1:0] x_usec;
  logic              x_add;

  // Stage 6 registers
  logic [SEC_W-1:0]  s6_nsec;
  logic [USEC_W-1:0] s6_usec;
  logic [ISEC_W-1:0] s6_isec;
  logic [USEC_W-1:0] s6_ims_us;
  logic [WSEC_W-1:0] s6_sec;
  logic [USEC_W-1:0] s6_usec_w;
  logic              s6_add;

  // Stage 7 logic
  logic [USEC_W:0]   usum;
  logic              ucarry;

  // Stage 7 registers
  logic [SEC_W-1:0]  s7_nsec;
  logic [USEC_W-1:0] s7_usec;
  logic [WSEC_W-1:0] s7_wsec;
  logic [USEC_W-1:0] s7_wusec;

  // Stage 8 logic
  logic [USEC_W:0]   udiff;
  logic              borrow;
  logic [WSEC_W:0]   sdiff;
  logic              late;
  result_t           res_next;

  // Coarse deadline from rounded milliseconds; a full second carries over
  assign up_sec  = rnd.msec == MS_W'(MS_PER_SEC);
  assign w1_sec  = rnd.bsec + WSEC_W'(up_sec);
  assign w1_usec = up_sec ? '0 : USEC_W'(rnd.msec) * USEC_W'(MS_PER_SEC);
  assign w1_past = (w1_sec < WSEC_W'(rnd.ctx.nsec))
                || ((w1_sec == WSEC_W'(rnd.ctx.nsec)) && (w1_usec < rnd.ctx.usec));

  // Very coarse: round now to the nearest second, add whole interval seconds
  assign vc_sec = WSEC_W'(rnd.ctx.nsec) + WSEC_W'(rnd.ctx.usec >= HALF_USEC)
                + WSEC_W'(rnd.ctx.isec);

  // Pick the start point and whether the interval is added to it
  always_comb begin
    case (rnd.ctx.kind)
      KIND_PRECISE: begin
        x_sec  = WSEC_W'(rnd.ctx.nsec);
        x_usec = rnd.ctx.usec;
        x_add  = 1'b1;
      end
      KIND_VERY_COARSE: begin
        x_sec  = vc_sec;
        x_usec = '0;
        x_add  = 1'b0;
      end
      default: begin
        // coarse, and the reserved code
        x_sec  = w1_sec;
        x_usec = w1_usec;
        x_add  = w1_past;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s6_nsec   <= rnd.ctx.nsec;
      s6_usec   <= rnd.ctx.usec;
      s6_isec   <= rnd.ctx.isec;
      s6_ims_us <= rnd.ctx.ims_us;
      s6_sec    <= x_sec;
      s6_usec_w <= x_usec;
      s6_add    <= x_add;
    end
  end

  // Add the interval where asked
  assign usum   = (USEC_W + 1)'(s6_usec_w) + (USEC_W + 1)'(s6_add ? s6_ims_us : '0);
  assign ucarry = usum >= (USEC_W + 1)'(USEC_PER_SEC);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s7_nsec  <= s6_nsec;
      s7_usec  <= s6_usec;
      s7_wusec <= ucarry ? USEC_W'(usum - (USEC_W + 1)'(USEC_PER_SEC)) : usum[USEC_W-1:0];
      s7_wsec  <= s6_sec + WSEC_W'(s6_add ? s6_isec : '0) + WSEC_W'(ucarry);
    end
  end

  // Delay from now; zero when the deadline lies in the past
  assign udiff  = (USEC_W + 1)'(s7_wusec) - (USEC_W + 1)'(s7_usec);
  assign borrow = udiff[USEC_W];
  assign sdiff  = (WSEC_W + 1)'(s7_wsec) - (WSEC_W + 1)'(s7_nsec) - (WSEC_W + 1)'(borrow);
  assign late   = sdiff[WSEC_W];

  always_comb begin
    res_next.when_sec  = s7_wsec;
    res_next.when_usec = s7_wusec;
    if (late) begin
      res_next.delta_sec  = '0;
      res_next.delta_usec = '0;
    end else begin
      res_next.delta_sec  = sdiff[SEC_W-1:0];
      res_next.delta_usec = borrow ? USEC_W'(udiff + (USEC_W + 1)'(USEC_PER_SEC))
                                   : udiff[USEC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the timer deadline coalescer: directed table, random items, scoreboard.
`timescale 1ns / 1ps

module tb;
  import tdc_pkg::*;

  // Kinds that the package leaves unnamed; the reserved code behaves as coarse
  localparam logic [KIND_W-1:0] KIND_COARSE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

  localparam longint unsigned US_PER_S  = 64'd1000000;
  localparam longint unsigned US_PER_MS = 64'd1000;
  localparam longint unsigned USEC_TOP  = 64'd999999;
  localparam longint unsigned USEC_HALF = 64'd500000;

  localparam int NUM_PHASES = 4;
  localparam int PHASE_ITEMS = 425;
  localparam int DRAIN_CYCLES = 3 * NUM_STAGES;

  typedef struct packed {
    logic [SEC_W-1:0]  nsec;
    logic [USEC_W-1:0] usec;
    logic [IVL_W-1:0]  ivl;
    logic [KIND_W-1:0] kind;
    logic              typed;
    result_t           wake;
  } stim_row_t;

  localparam result_t NO_WAKE = '0;
  localparam int NDIR = 26;

  // Directed rows: extremes, every kind, clamped microseconds, deadlines in the past
  stim_row_t dir_rows [NDIR] = '{
    '{32'd0, 20'd0, 31'd0, KIND_PRECISE, 1'b1, '{33'd0, 20'd0, 32'd0, 20'd0}},
    '{32'd5, 20'hFFFFF, 31'd0, KIND_PRECISE, 1'b1, '{33'd5, 20'd999999, 32'd0, 20'd0}},
    '{32'hFFFFFFFF, 20'd999999, 31'h7FFFFFFF, KIND_PRECISE, 1'b1,
      '{33'd4297114779, 20'd646999, 32'd2147483, 20'd647000}},
    '{32'd100, 20'd400000, 31'd0, KIND_VERY_COARSE, 1'b1, '{33'd100, 20'd0, 32'd0, 20'd0}},
    '{32'd100, 20'd500000, 31'd0, KIND_VERY_COARSE, 1'b1,
      '{33'd101, 20'd0, 32'd0, 20'd500000}},
    '{32'hFFFFFFFF, 20'd999999, 31'h7FFFFFFF, KIND_VERY_COARSE, 1'b1,
      '{33'd4297114779, 20'd0, 32'd2147483, 20'd1}},
    '{32'd7, 20'd123456, 31'd0, KIND_RESERVED, 1'b1, '{33'd7, 20'd123000, 32'd0, 20'd0}},
    '{32'd1000, 20'd250000, 31'd1500, KIND_PRECISE, 1'b0, NO_WAKE},
    '{32'd42, 20'd999999, 31'd999, KIND_VERY_COARSE, 1'b0, NO_WAKE},
    '{32'd42, 20'd700000, 31'd1000, KIND_VERY_COARSE, 1'b0, NO_WAKE},
    '{32'd12, 20'd345678, 31'd10, KIND_COARSE, 1'b0, NO_WAKE},
    '{32'd12, 20'd987654, 31'd30, KIND_COARSE, 1'b0, NO_WAKE},
    '{32'd300, 20'd456789, 31'd60, KIND_COARSE, 1'b0, NO_WAKE},
    '{32'd300, 20'd456789, 31'd75, KIND_COARSE, 1'b0, NO_WAKE},
    '{32'd9, 20'd100000, 31'd100, KIND_COARSE, 1'b0, NO_WAKE},
    '{32'd9, 20'd620000, 31'd150, KIND_COARSE, 1'b0, NO_WAKE},
    '{32'd9, 20'd333000, 31'd200, KIND_COARSE, 1'b0, NO_WAKE},
    '{32'd9, 20'd777000, 31'd250, KIND_COARSE, 1'b0, NO_WAKE},
    '{32'd9, 20'd480000, 31'd300, KIND_COARSE, 1'b0, NO_WAKE},
    '{32'd9, 20'd240000, 31'd500, KIND_COARSE, 1'b0, NO_WAKE},
    '{32'd77, 20'd600000, 31'd5000, KIND_COARSE, 1'b0, NO_WAKE},
    '{32'd77, 20'd300000, 31'd10000, KIND_COARSE, 1'b0, NO_WAKE},
    '{32'd77, 20'd555555, 31'd1234, KIND_COARSE, 1'b0, NO_WAKE},
    '{32'd77, 20'd999999, 31'd1, KIND_COARSE, 1'b0, NO_WAKE},
    '{32'hFFFFFFFF, 20'hFFFFF, 31'h7FFFFFFF, KIND_COARSE, 1'b0, NO_WAKE},
    '{32'd0, 20'd0, 31'd0, KIND_COARSE, 1'b0, NO_WAKE}
  };

  logic clk;
  logic rst;
  result_t pend_wake;          // expected wake-up for the beat now on offer
  result_t wake_q [$];         // expected wake-ups in acceptance order
  int fail_count;
  int idle_pct;
  int stall_pct;

  tdc_in_if  timer_ch ();
  tdc_out_if wake_ch ();

  timer_deadline_coalescer dut (
    .clk    (clk),
    .rst    (rst),
    .item   (timer_ch.sink),
    .result (wake_ch.source)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Move the millisecond fraction of a coarse deadline toward a preferred boundary
  function automatic longint snap_msec(input longint ivl, input longint msec);
    longint maxr, lo, hi, bnd, base, q, up;
    maxr = ivl / 20;
    // Short odd intervals: round to even or to a multiple of four
    if ((ivl < 100) && ((ivl % 25) != 0)) begin
      if (ivl < 50) begin
        up = ((msec % 50) >= 25) ? 1 : 0;
        return ((msec >> 1) | up) << 1;
      end
      up = ((msec % 100) >= 50) ? 1 : 0;
      return ((msec >> 2) | up) << 2;
    end
    lo = (msec - maxr > 0) ? msec - maxr : 0;
    hi = (msec + maxr < 1000) ? msec + maxr : 1000;
    if (lo == 0)
      return 0;
    if (hi == 1000)
      return 1000;
    // Pick the boundary from the interval's divisibility
    if ((ivl % 500) == 0) begin
      if (ivl >= 5000)
        return (msec >= 500) ? hi : lo;
      bnd = 500;
    end else if ((ivl % 50) == 0) begin
      q = ivl / 50;
      if ((q % 4) == 0)
        bnd = 200;
      else if ((q % 2) == 0)
        bnd = 100;
      else if ((q % 5) == 0)
        bnd = 250;
      else
        bnd = 50;
    end else begin
      bnd = 25;
    end
    base = (msec / bnd) * bnd;
    if (msec < base + bnd / 2)
      return (base > lo) ? base : lo;
    return (base + bnd < hi) ? base + bnd : hi;
  endfunction

  // Work out the wake-up time and the delay until it, exact in 64 bits
  function automatic result_t predict_wakeup(input logic [SEC_W-1:0] nsec,
                                             input logic [USEC_W-1:0] usec_in,
                                             input logic [IVL_W-1:0] ivl,
                                             input logic [KIND_W-1:0] kind);
    longint unsigned usec, now_t, ivl_us, s, t, bsec, w, d, sec64;
    longint ivl_s, msec;
    result_t r;
    usec = 64'(usec_in);
    if (usec > USEC_TOP)
      usec = USEC_TOP;
    sec64 = 64'(nsec);
    ivl_s = 64'(ivl);
    now_t = sec64 * US_PER_S + usec;
    ivl_us = ivl_s * US_PER_MS;
    if (kind == KIND_PRECISE) begin
      w = now_t + ivl_us;
    end else if (kind == KIND_VERY_COARSE) begin
      // Round now to the nearest second, add whole seconds of the interval
      s = sec64 + ((usec >= USEC_HALF) ? 64'd1 : 64'd0) + ivl_s / US_PER_MS;
      if (s <= sec64)
        s = sec64 + ivl_s / US_PER_MS;
      w = s * US_PER_S;
    end else begin
      t = now_t + ivl_us;
      bsec = t / US_PER_S;
      msec = longint'((t % US_PER_S) / US_PER_MS);
      msec = snap_msec(ivl_s, msec);
      w = bsec * US_PER_S + longint'(msec) * US_PER_MS;
      // Push a deadline that fell into the past one interval further
      if (w < now_t)
        w = w + ivl_us;
    end
    d = (w >= now_t) ? w - now_t : 64'd0;
    r.when_sec   = WSEC_W'(w / US_PER_S);
    r.when_usec  = USEC_W'(w % US_PER_S);
    r.delta_sec  = SEC_W'(d / US_PER_S);
    r.delta_usec = USEC_W'(d % US_PER_S);
    return r;
  endfunction

  // Offer one timer beat, idling first at the current rate, and hold it until taken
  task automatic send_timer(input logic [SEC_W-1:0] nsec, input logic [USEC_W-1:0] usec,
                            input logic [IVL_W-1:0] ivl, input logic [KIND_W-1:0] kind,
                            input result_t wake);
    while ($urandom_range(0, 99) < idle_pct) begin
      timer_ch.valid <= 1'b0;
      @(posedge clk);
    end
    timer_ch.valid       <= 1'b1;
    timer_ch.now_sec     <= nsec;
    timer_ch.now_usec    <= usec;
    timer_ch.interval_ms <= ivl;
    timer_ch.kind        <= kind;
    pend_wake            <= wake;
    @(posedge clk);
    while (!timer_ch.ready)
      @(posedge clk);
  endtask

  // Stall the result channel at the current rate
  initial begin
    wake_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      wake_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Record accepted timer beats and check result beats against the oldest expectation
  always @(posedge clk) begin : scoreboard
    result_t want;
    if (!rst) begin
      if (timer_ch.valid && timer_ch.ready)
        wake_q.push_back(pend_wake);
      if (wake_ch.valid && wake_ch.ready) begin
        if (wake_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count++;
        end else begin
          want = wake_q.pop_front();
          if (wake_ch.when_sec !== want.when_sec) begin
            $error("when_sec: expected %0d, got %0d", want.when_sec, wake_ch.when_sec);
            fail_count++;
          end
          if (wake_ch.when_usec !== want.when_usec) begin
            $error("when_usec: expected %0d, got %0d", want.when_usec, wake_ch.when_usec);
            fail_count++;
          end
          if (wake_ch.delta_sec !== want.delta_sec) begin
            $error("delta_sec: expected %0d, got %0d", want.delta_sec, wake_ch.delta_sec);
            fail_count++;
          end
          if (wake_ch.delta_usec !== want.delta_usec) begin
            $error("delta_usec: expected %0d, got %0d", want.delta_usec,
                   wake_ch.delta_usec);
            fail_count++;
          end
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain
  initial begin : stimulus
    int unsigned k;
    int ph, n;
    stim_row_t row;
    logic [SEC_W-1:0]  nsec;
    logic [USEC_W-1:0] usec;
    logic [IVL_W-1:0]  ivl;
    logic [KIND_W-1:0] kind;
    int idle_tab [NUM_PHASES];
    int stall_tab [NUM_PHASES];
    idle_tab  = '{0, 82, 0, 25};
    stall_tab = '{0, 0, 82, 25};
    fail_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst <= 1'b1;
    timer_ch.valid       <= 1'b0;
    timer_ch.now_sec     <= '0;
    timer_ch.now_usec    <= '0;
    timer_ch.interval_ms <= '0;
    timer_ch.kind        <= KIND_PRECISE;
    pend_wake            <= NO_WAKE;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table; typed rows carry their own expectation
    for (k = 0; k < NDIR; k++) begin
      row = dir_rows[k];
      send_timer(row.nsec, row.usec, row.ivl, row.kind,
                 row.typed ? row.wake : predict_wakeup(row.nsec, row.usec, row.ivl, row.kind));
    end

    // Random items under each mix of idling and result stalls
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      for (n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          0: nsec = ($urandom_range(0, 1) != 0) ? 32'hFFFFFFFF - $urandom_range(0, 1)
                                                : $urandom_range(0, 1);
          default: nsec = $urandom;
        endcase
        case ($urandom_range(0, 19))
          0: usec = USEC_W'($urandom_range(1000000, 20'hFFFFF));
          1: usec = ($urandom_range(0, 1) != 0) ? 20'd999999 : 20'd0;
          2: usec = USEC_W'(20'd499999 + $urandom_range(0, 1));
          default: usec = USEC_W'($urandom_range(0, 999999));
        endcase
        case ($urandom_range(0, 9))
          0: ivl = IVL_W'($urandom_range(0, 120));
          1: ivl = IVL_W'(25 * $urandom_range(0, 400));
          2: ivl = IVL_W'(50 * $urandom_range(0, 200));
          3: ivl = IVL_W'(500 * $urandom_range(0, 40));
          4: ivl = IVL_W'($urandom_range(0, 2000));
          5: ivl = IVL_W'($urandom_range(0, 100000));
          6: ivl = IVL_W'($urandom);
          7: ivl = IVL_W'($urandom_range(4990, 5010));
          8: ivl = IVL_W'($urandom_range(0, 20));
          default: ivl = IVL_W'(1000 * $urandom_range(0, 3000));
        endcase
        kind = KIND_W'($urandom_range(0, 3));
        send_timer(nsec, usec, ivl, kind, predict_wakeup(nsec, usec, ivl, kind));
      end
    end

    // Drain: stop offering, open the result side, wait out the pipeline
    timer_ch.valid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    while (wake_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && wake_q.size() == 0) begin
      $display("[timer_deadline_coalescer] OK");
    end else begin
      $display("[timer_deadline_coalescer] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2_000_000;
    $display("[timer_deadline_coalescer] ERROR");
    $finish;
  end

endmodule
